@@ hdl/rpcfo_pkg.sv @@
// ----------------------------------------------------------------------------
// rpcfo_pkg
// Shared widths, register indexes, command/status bundles and the CORDIC
// arctangent table of the repeated-preamble CFO estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpcfo_pkg;

  localparam int HALF_LEN_W   = 11;
  localparam int FREQ_W       = 32;
  localparam int CFO_W        = 32;
  localparam int TURN_W       = 32;
  localparam int CORDIC_ITERS = 32;
  localparam int ITER_W       = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_SCALE  = 2'd1;

  localparam logic [HALF_LEN_W-1:0] HALF_LEN_RESET   = 11'd64;
  localparam logic [FREQ_W-1:0]     FREQ_SCALE_RESET = 32'd65536;

  typedef struct packed {
    logic              accept;
    logic              mul;
    logic              acc;
    logic              load;
    logic              norm;
    logic              rot;
    logic [ITER_W-1:0] iter;
    logic              round;
    logic              scale;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic second;
    logic last;
    logic zero;
    logic big;
  } stat_t;

  function automatic logic [TURN_W-1:0] atan_turn(input logic [ITER_W-1:0] k);
    logic [TURN_W-1:0] v;
    unique case (k)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rpcfo_ctrl.sv @@
// ----------------------------------------------------------------------------
// rpcfo_ctrl
// Sequencer: steps the datapath through sample intake, correlation
// accumulate, normalization, CORDIC vectoring, scaling and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcfo_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  rpcfo_pkg::stat_t    stat,
  output rpcfo_pkg::cmd_t     cmd
);
  import rpcfo_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_NORM  = 4'd4;
  localparam logic [3:0] S_ROT   = 4'd5;
  localparam logic [3:0] S_ROUND = 4'd6;
  localparam logic [3:0] S_SCALE = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_ITERS - 1);

  logic [3:0]        state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && stat.second) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = stat.last ? S_LOAD : S_IDLE;
      S_LOAD:  state_nxt = stat.zero ? S_SCALE : S_NORM;
      S_NORM: begin
        if (!stat.big) begin
          state_nxt = S_ROT;
          iter_nxt  = '0;
        end
      end
      S_ROT: begin
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == LAST_ITER) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_EMIT;
      S_EMIT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.accept = accept;
    cmd.mul    = (state_r == S_MUL);
    cmd.acc    = (state_r == S_ACC);
    cmd.load   = (state_r == S_LOAD);
    cmd.norm   = (state_r == S_NORM);
    cmd.rot    = (state_r == S_ROT);
    cmd.iter   = iter_r;
    cmd.round  = (state_r == S_ROUND);
    cmd.scale  = (state_r == S_SCALE);
    cmd.emit   = (state_r == S_EMIT);
  end

  a_rot_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT && iter_r == LAST_ITER) |=> (state_r == S_ROUND))
    else $error("CORDIC did not finish after the last iteration");

  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |=> (state_r == S_IDLE))
    else $error("result stage not followed by idle");

endmodule

`default_nettype wire

@@ hdl/rpcfo_dp.sv @@
// ----------------------------------------------------------------------------
// rpcfo_dp
// Datapath: first-half sample store, conjugate-product accumulators,
// magnitude normalizer, shared CORDIC vectoring stage and frequency scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module rpcfo_dp #(
  parameter int MAX_HALF    = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int ANGLE_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  rpcfo_pkg::cmd_t                           cmd,
  output rpcfo_pkg::stat_t                          stat,
  input  wire logic signed [SAMPLE_BITS-1:0]        sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        sample_q,
  input  wire logic                                 cfg_we,
  input  wire logic [rpcfo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rpcfo_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                      out_valid,
  output logic signed [rpcfo_pkg::CFO_W-1:0]        out_cfo_estimate
);
  import rpcfo_pkg::*;

  localparam int AW       = $clog2(MAX_HALF);
  localparam int POS_W    = AW + 1;
  localparam int PR_W     = 2 * SAMPLE_BITS;
  localparam int ACC_FULL = 2 * SAMPLE_BITS + 1 + $clog2(MAX_HALF);
  localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
  localparam int CW       = 34;
  localparam int PW       = ANGLE_BITS + FREQ_W;
  localparam int RW       = PW - 8;

  // configuration
  logic [HALF_LEN_W-1:0] half_len_r;
  logic [FREQ_W-1:0]     freq_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_len_r   <= HALF_LEN_RESET;
      freq_scale_r <= FREQ_SCALE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_HALF_LENGTH) begin
        half_len_r <= cfg_data[HALF_LEN_W-1:0];
      end else if (cfg_index == REG_FREQ_SCALE) begin
        freq_scale_r <= cfg_data[FREQ_W-1:0];
      end
    end
  end

  // position tracking
  logic [POS_W-1:0] eff_len;
  logic [POS_W:0]   two_eff;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] p0;
  logic [POS_W:0]   p1;
  logic [POS_W-1:0] pdiff;
  logic             wrap, second, is_last;
  logic             last_r;
  logic [AW-1:0]    mem_addr;

  always_comb begin
    if (32'(half_len_r) > MAX_HALF) begin
      eff_len = POS_W'(MAX_HALF);
    end else if (half_len_r == '0) begin
      eff_len = POS_W'(1);
    end else begin
      eff_len = POS_W'(half_len_r);
    end
  end

  assign two_eff  = {eff_len, 1'b0};
  assign wrap     = ({1'b0, pos_r} >= two_eff);
  assign p0       = wrap ? '0 : pos_r;
  assign second   = (p0 >= eff_len);
  assign p1       = {1'b0, p0} + (POS_W+1)'(1);
  assign is_last  = (p1 >= two_eff);
  assign pdiff    = p0 - eff_len;
  assign mem_addr = second ? pdiff[AW-1:0] : p0[AW-1:0];
  assign pos_nxt  = is_last ? '0 : p1[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      last_r <= 1'b0;
    end else if (cmd.accept) begin
      pos_r  <= pos_nxt;
      last_r <= is_last;
    end
  end

  // first-half store
  logic [PR_W-1:0] ram [MAX_HALF];
  logic [PR_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (second) begin
        rd_r <= ram[mem_addr];
      end else begin
        ram[mem_addr] <= {sample_i, sample_q};
      end
    end
  end

  // conjugate products and accumulators
  logic signed [SAMPLE_BITS-1:0] si_r, sq_r;
  logic signed [SAMPLE_BITS-1:0] ai, aq;
  logic signed [PR_W-1:0]        p_ii_r, p_qq_r, p_iq_r, p_qi_r;
  logic signed [ACC_W-1:0]       re_sum_r, im_sum_r;

  assign ai = rd_r[PR_W-1:SAMPLE_BITS];
  assign aq = rd_r[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      si_r <= sample_i;
      sq_r <= sample_q;
    end
    if (cmd.mul) begin
      p_ii_r <= PR_W'(ai) * PR_W'(si_r);
      p_qq_r <= PR_W'(aq) * PR_W'(sq_r);
      p_iq_r <= PR_W'(ai) * PR_W'(sq_r);
      p_qi_r <= PR_W'(aq) * PR_W'(si_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      re_sum_r <= '0;
      im_sum_r <= '0;
    end else if (cmd.accept && wrap) begin
      re_sum_r <= '0;
      im_sum_r <= '0;
    end else if (cmd.acc) begin
      re_sum_r <= re_sum_r + ACC_W'(p_ii_r) + ACC_W'(p_qq_r);
      im_sum_r <= im_sum_r + ACC_W'(p_iq_r) - ACC_W'(p_qi_r);
    end else if (cmd.load) begin
      re_sum_r <= '0;
      im_sum_r <= '0;
    end
  end

  // sign-magnitude and normalization
  logic [ACC_W-1:0] mx_r, my_r;
  logic             nx_r, ny_r;
  logic [63:0]      mx64, my64;
  logic             big, zero, flip, neg_y;
  logic signed [CW-1:0] x_init, y_mag;

  assign mx64  = 64'(mx_r);
  assign my64  = 64'(my_r);
  assign big   = (mx64 >= 64'h4000_0000) || (my64 >= 64'h4000_0000);
  assign zero  = (re_sum_r == '0) && (im_sum_r == '0);
  assign flip  = nx_r && (mx_r != '0);
  assign neg_y = flip ? !ny_r : ny_r;
  assign x_init = CW'(mx64[30:0]);
  assign y_mag  = CW'(my64[30:0]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nx_r <= re_sum_r[ACC_W-1];
      ny_r <= im_sum_r[ACC_W-1];
      mx_r <= re_sum_r[ACC_W-1] ? ACC_W'(-re_sum_r) : ACC_W'(re_sum_r);
      my_r <= im_sum_r[ACC_W-1] ? ACC_W'(-im_sum_r) : ACC_W'(im_sum_r);
    end else if (cmd.norm && big) begin
      mx_r <= mx_r >> 1;
      my_r <= my_r >> 1;
    end
  end

  // CORDIC vectoring, one iteration per cycle
  logic signed [CW-1:0]  x_r, y_r, sx, sy;
  logic [TURN_W-1:0]     z_r, z_rnd, atan_k;
  logic signed [ANGLE_BITS-1:0] code_r;

  assign sx     = x_r >>> cmd.iter;
  assign sy     = y_r >>> cmd.iter;
  assign atan_k = atan_turn(cmd.iter);
  assign z_rnd  = z_r + (TURN_W'(1) << (TURN_W - 1 - ANGLE_BITS));

  always_ff @(posedge clk) begin
    if (cmd.norm && !big) begin
      x_r <= x_init;
      y_r <= neg_y ? -y_mag : y_mag;
      z_r <= flip ? {1'b1, {(TURN_W-1){1'b0}}} : '0;
    end else if (cmd.rot) begin
      if (y_r[CW-1]) begin
        x_r <= x_r - sy;
        y_r <= y_r + sx;
        z_r <= z_r - atan_k;
      end else begin
        x_r <= x_r + sy;
        y_r <= y_r - sx;
        z_r <= z_r + atan_k;
      end
    end
    if (cmd.load) begin
      code_r <= '0;
    end else if (cmd.round) begin
      code_r <= z_rnd[TURN_W-1 -: ANGLE_BITS];
    end
  end

  // frequency scaling, round to Q25.7, saturate
  logic [ANGLE_BITS-1:0] code_mag;
  logic [PW-1:0]         prod_r;
  logic                  neg_r;
  logic [PW:0]           rnd;
  logic [RW-1:0]         rmag, rneg;
  logic [CFO_W-1:0]      cfo_val;
  logic                  out_valid_r;
  logic signed [CFO_W-1:0] out_cfo_r;

  assign code_mag = code_r[ANGLE_BITS-1] ? ANGLE_BITS'(-code_r) : ANGLE_BITS'(code_r);
  assign rnd      = (PW+1)'(prod_r) + (PW+1)'(256);
  assign rmag     = rnd[PW:9];
  assign rneg     = -rmag;

  always_comb begin
    if (neg_r) begin
      cfo_val = (rmag > RW'(64'h8000_0000)) ? 32'h8000_0000 : rneg[CFO_W-1:0];
    end else begin
      cfo_val = (rmag > RW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : rmag[CFO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      prod_r <= PW'(code_mag) * PW'(freq_scale_r);
      neg_r  <= code_r[ANGLE_BITS-1];
    end
    if (cmd.emit) begin
      out_cfo_r <= cfo_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cfo_estimate = out_cfo_r;

  always_comb begin
    stat        = '0;
    stat.second = second;
    stat.last   = last_r;
    stat.zero   = zero;
    stat.big    = big;
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rot |-> !x_r[CW-1])
    else $error("CORDIC x went negative");

  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && is_last) |=> (pos_r == '0))
    else $error("position not restarted after the last sample");

endmodule

`default_nettype wire

@@ hdl/repeated_preamble_cfo_estimator_top.sv @@
// ----------------------------------------------------------------------------
// repeated_preamble_cfo_estimator_top
// Carrier frequency offset estimator over a repeated training sequence.
//
// channel  direction  handshake             payload
// in       input      start & !busy         in_sample_i, in_sample_q
// out      output     out_valid (1 cycle)   out_cfo_estimate
// cfg      input      cfg_valid & cfg_ready cfg_index, cfg_data
//
// First-half sample: store write. Second-half sample: store read, product
// register, accumulate.
// The last sample adds the load step, normalization (right shifts until the
// correlation is below 2^30, up to ACC_W-30 shifts, 13 at defaults), the
// CORDIC iterations, round, scale and result; out_valid rises the cycle after.
// A zero correlation skips normalize, CORDIC and round.
// Reset is synchronous; no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module repeated_preamble_cfo_estimator_top #(
  parameter int MAX_HALF    = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int ANGLE_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_sample_q,
  output logic                                      out_valid,
  output logic signed [rpcfo_pkg::CFO_W-1:0]        out_cfo_estimate,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [rpcfo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rpcfo_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rpcfo_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  rpcfo_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rpcfo_dp #(
    .MAX_HALF    (MAX_HALF),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .sample_i         (in_sample_i),
    .sample_q         (in_sample_q),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_cfo_estimate (out_cfo_estimate)
  );

endmodule

`default_nettype wire
